// ===== rtl/wlcl_pkg.sv =====
// Shared types and constants for the window/level colour lookup core.
// Used by wlcl_table and window_level_color_lookup_core; depends on nothing.
package wlcl_pkg;

  // Kind of input word, carried on the input tuser bit.
  typedef enum logic {
    OP_MAP   = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Where a sample falls relative to the window.
  typedef enum logic [1:0] {
    CLS_LOW  = 2'd0,
    CLS_HIGH = 2'd1,
    CLS_MID  = 2'd2
  } cls_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_WINDOW_LOW     = 3'd0,
    REG_WINDOW_HIGH    = 3'd1,
    REG_INDEX_SCALE    = 3'd2,
    REG_TABLE_SIZE     = 3'd3,
    REG_REVERSE_MODE   = 3'd4,
    REG_PADDING_ENABLE = 3'd5,
    REG_PADDING_VALUE  = 3'd6,
    REG_ALPHA_ENABLE   = 3'd7
  } cfg_reg_t;

  localparam int unsigned WIN_W    = 16;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned TSIZE_W  = 9;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned ADDR_W   = 8;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned COLOR_W  = 24;
  localparam int unsigned DIFF_W   = 16;
  localparam int unsigned PROD_W   = 40;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned OUT_W    = 32;

  localparam logic [CHAN_W-1:0] ALPHA_ON  = 8'd255;
  localparam logic [CHAN_W-1:0] ALPHA_OFF = 8'd0;

endpackage

// ===== rtl/wlcl_table.sv =====
// Colour table storage: one port, written or read each cycle, read data registered.
// Depends on wlcl_pkg for the entry width.
module wlcl_table #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic                        rd_en,
  input  logic [AW-1:0]               addr,
  input  logic [wlcl_pkg::COLOR_W-1:0] wdata,
  output logic [wlcl_pkg::COLOR_W-1:0] rdata
);

  logic [wlcl_pkg::COLOR_W-1:0] mem [DEPTH];
  logic [wlcl_pkg::COLOR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/window_level_color_lookup_core.sv =====
// Window/level colour lookup core: maps signed samples to RGBA words through a loaded
// colour table. Depends on wlcl_pkg and wlcl_table.
//
// One word is taken per clock while in_tready is high; a mapped pixel leaves once its
// sample passes padding substitution, window compare and offset, the scale multiply,
// index clamp and mirror, then the table read. Table writes travel down the same
// pipeline and are committed at the table port in the slot where a sample would read
// it, so a sample always sees every in-range write accepted before it. Write words give no
// output word. Each stage holds its word under backpressure and stages with a bubble
// keep filling, so in_tready only drops when all five stages are occupied.
module window_level_color_lookup_core #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,

  input  logic                          in_tvalid,
  output logic                          in_tready,
  // sample, entry_index, entry_red, entry_green, entry_blue, zero padding
  input  logic [((SAMPLE_BITS+32+7)/8)*8-1:0] in_tdata,
  // operation
  input  logic                          in_tuser,
  input  logic                          in_tlast,

  output logic                          out_tvalid,
  input  logic                          out_tready,
  // pixel_red, pixel_green, pixel_blue, pixel_alpha
  output logic [wlcl_pkg::OUT_W-1:0]    out_tdata,
  output logic                          out_tlast,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [wlcl_pkg::CFG_W-1:0]    cfg_data
);

  localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
  localparam int unsigned CW    = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;

  // ---------------------------------------------------------------- configuration
  logic [wlcl_pkg::WIN_W-1:0]   cfg_low_r, cfg_high_r, cfg_pad_r;
  logic [wlcl_pkg::SCALE_W-1:0] cfg_scale_r;
  logic [wlcl_pkg::TSIZE_W-1:0] cfg_tsize_r;
  logic                         cfg_rev_r, cfg_pad_en_r, cfg_alpha_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_low_r    <= '0;
      cfg_high_r   <= 16'd4095;
      cfg_scale_r  <= 24'd4081;
      cfg_tsize_r  <= 9'd256;
      cfg_rev_r    <= 1'b0;
      cfg_pad_en_r <= 1'b0;
      cfg_pad_r    <= '0;
      cfg_alpha_r  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (wlcl_pkg::cfg_reg_t'(cfg_index))
        wlcl_pkg::REG_WINDOW_LOW:     cfg_low_r    <= cfg_data[15:0];
        wlcl_pkg::REG_WINDOW_HIGH:    cfg_high_r   <= cfg_data[15:0];
        wlcl_pkg::REG_INDEX_SCALE:    cfg_scale_r  <= cfg_data;
        wlcl_pkg::REG_TABLE_SIZE:     cfg_tsize_r  <= cfg_data[8:0];
        wlcl_pkg::REG_REVERSE_MODE:   cfg_rev_r    <= cfg_data[0];
        wlcl_pkg::REG_PADDING_ENABLE: cfg_pad_en_r <= cfg_data[0];
        wlcl_pkg::REG_PADDING_VALUE:  cfg_pad_r    <= cfg_data[15:0];
        wlcl_pkg::REG_ALPHA_ENABLE:   cfg_alpha_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Last table entry in use; a size of zero counts as one entry.
  logic [31:0]      tsize_c;
  logic [IDX_W-1:0] last_c;

  always_comb begin
    tsize_c = 32'(cfg_tsize_r);
    if (tsize_c == 32'd0) begin
      tsize_c = 32'd1;
    end else if (tsize_c > 32'(TABLE_DEPTH)) begin
      tsize_c = 32'(TABLE_DEPTH);
    end
    last_c = IDX_W'(tsize_c - 32'd1);
  end

  // ---------------------------------------------------------------- stage enables
  logic en1, en2, en3, en4, en_out;
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;

  assign en_out    = !out_valid_r || out_tready;
  assign en4       = !v4_r || en_out;
  assign en3       = !v3_r || en4;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_tvalid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  // ---------------------------------------------------------------- stage 1: padding
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [CW-1:0]          in_sample_x, pad_x;
  logic [SAMPLE_BITS-1:0] smp1_nxt, smp1_r;
  wlcl_pkg::op_t          op1_r, op2_r, op3_r, op4_r;
  logic                   fe1_r, fe2_r, fe3_r, fe4_r;
  logic [wlcl_pkg::ADDR_W-1:0]  wadr1_r, wadr2_r, wadr3_r;
  logic [wlcl_pkg::COLOR_W-1:0] wdat1_r, wdat2_r, wdat3_r, wdat4_r;

  assign in_sample   = in_tdata[SAMPLE_BITS-1:0];
  assign in_sample_x = {{(CW-SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample};
  assign pad_x       = {{(CW-16){cfg_pad_r[15]}}, cfg_pad_r};
  assign smp1_nxt    = (cfg_pad_en_r && (in_sample_x == pad_x)) ? '0 : in_sample;

  always_ff @(posedge clk) begin
    if (en1) begin
      smp1_r  <= smp1_nxt;
      op1_r   <= wlcl_pkg::op_t'(in_tuser);
      fe1_r   <= in_tlast;
      wadr1_r <= in_tdata[SAMPLE_BITS +: 8];
      // Stored with red in the top byte.
      wdat1_r <= {in_tdata[SAMPLE_BITS+8 +: 8], in_tdata[SAMPLE_BITS+16 +: 8],
                  in_tdata[SAMPLE_BITS+24 +: 8]};
    end
  end

  // ---------------------------------------------------------------- stage 2: window
  logic [CW-1:0]              s_x, lo_x, hi_x, off_x;
  wlcl_pkg::cls_t             cls2_nxt, cls2_r, cls3_r;
  logic [wlcl_pkg::DIFF_W-1:0] diff2_r;

  assign s_x   = {{(CW-SAMPLE_BITS){smp1_r[SAMPLE_BITS-1]}}, smp1_r};
  assign lo_x  = {{(CW-16){cfg_low_r[15]}}, cfg_low_r};
  assign hi_x  = {{(CW-16){cfg_high_r[15]}}, cfg_high_r};
  assign off_x = s_x - lo_x;

  // The low test wins when the window is inverted.
  always_comb begin
    if ($signed(s_x) <= $signed(lo_x)) begin
      cls2_nxt = wlcl_pkg::CLS_LOW;
    end else if ($signed(s_x) >= $signed(hi_x)) begin
      cls2_nxt = wlcl_pkg::CLS_HIGH;
    end else begin
      cls2_nxt = wlcl_pkg::CLS_MID;
    end
  end

  // Inside the window the offset is below 65535, so sixteen bits hold it.
  always_ff @(posedge clk) begin
    if (en2) begin
      cls2_r  <= cls2_nxt;
      diff2_r <= off_x[wlcl_pkg::DIFF_W-1:0];
      op2_r   <= op1_r;
      fe2_r   <= fe1_r;
      wadr2_r <= wadr1_r;
      wdat2_r <= wdat1_r;
    end
  end

  // ---------------------------------------------------------------- stage 3: scale
  logic [wlcl_pkg::PROD_W-1:0] prod3_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      prod3_r <= wlcl_pkg::PROD_W'(diff2_r) * wlcl_pkg::PROD_W'(cfg_scale_r);
      cls3_r  <= cls2_r;
      op3_r   <= op2_r;
      fe3_r   <= fe2_r;
      wadr3_r <= wadr2_r;
      wdat3_r <= wdat2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4: index
  logic [wlcl_pkg::SCALE_W-1:0] raw_idx;
  logic [IDX_W-1:0]             idx_c, addr4_nxt, addr4_r;
  logic                         wok4_nxt, wok4_r;

  assign raw_idx = prod3_r[wlcl_pkg::PROD_W-1:wlcl_pkg::FRAC_W];

  always_comb begin
    unique case (cls3_r)
      wlcl_pkg::CLS_LOW:  idx_c = '0;
      wlcl_pkg::CLS_HIGH: idx_c = last_c;
      default: begin
        if (raw_idx > wlcl_pkg::SCALE_W'(last_c)) begin
          idx_c = last_c;
        end else begin
          idx_c = raw_idx[IDX_W-1:0];
        end
      end
    endcase
    if (cfg_rev_r) begin
      idx_c = last_c - idx_c;
    end
    if (op3_r == wlcl_pkg::OP_WRITE) begin
      addr4_nxt = IDX_W'(32'(wadr3_r));
    end else begin
      addr4_nxt = idx_c;
    end
    // Writes beyond the table are dropped.
    wok4_nxt = (32'(wadr3_r) < 32'(TABLE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      addr4_r <= addr4_nxt;
      wok4_r  <= wok4_nxt;
      op4_r   <= op3_r;
      fe4_r   <= fe3_r;
      wdat4_r <= wdat3_r;
    end
  end

  // ---------------------------------------------------------------- stage 5: table
  logic                         tbl_wr, tbl_rd;
  logic [wlcl_pkg::COLOR_W-1:0] tbl_q;
  logic [wlcl_pkg::CHAN_W-1:0]  alpha_r;
  logic                         last_r;

  assign tbl_wr = en_out && v4_r && (op4_r == wlcl_pkg::OP_WRITE) && wok4_r;
  assign tbl_rd = en_out && v4_r && (op4_r == wlcl_pkg::OP_MAP);

  wlcl_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .wr_en (tbl_wr),
    .rd_en (tbl_rd),
    .addr  (addr4_r),
    .wdata (wdat4_r),
    .rdata (tbl_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v4_r && (op4_r == wlcl_pkg::OP_MAP);
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_rd) begin
      alpha_r <= cfg_alpha_r ? wlcl_pkg::ALPHA_ON : wlcl_pkg::ALPHA_OFF;
      last_r  <= fe4_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {alpha_r, tbl_q[7:0], tbl_q[15:8], tbl_q[23:16]};
  assign out_tlast  = last_r;

  // ---------------------------------------------------------------- assertions
  a_write_no_word: assert property (@(posedge clk) disable iff (!rst_n)
    (en_out && v4_r && (op4_r == wlcl_pkg::OP_WRITE)) |=> !out_valid_r)
    else $error("table write produced an output word");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r && v4_r && out_valid_r))
    else $error("input stalled while a stage had a bubble");

  a_index_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && (op4_r == wlcl_pkg::OP_MAP)) |-> (addr4_r <= last_c))
    else $error("map index beyond last entry in use");

  a_read_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_rd |=> out_valid_r)
    else $error("table read without an output word");

endmodule
